### design/fdre_pkg.sv
`default_nettype none

package fdre_pkg;

  // Default longest run, in bytes
  localparam int MAX_RUN_DEF = 32;

  // Match run header flag
  localparam logic [7:0] MATCH_FLAG = 8'h80;

  // End-of-frame marker byte
  localparam logic [7:0] END_MARK = 8'h00;

  // Run kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_LITERAL = 1'b1;

  typedef struct packed {
    logic [7:0] prev_byte;
    logic [7:0] new_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_last;
    logic       frame_done;
  } out_t;

endpackage

`default_nettype wire

### design/frame_delta_run_encoder.sv
// Frame delta run encoder.
// Input channel (in_valid/in_ready/in_data) takes one byte pair per
// transaction: the previous frame's byte, the new frame's byte and an
// end-of-frame flag. Output channel (out_valid/out_ready/out_data) gives
// code bytes one per transaction: match headers (0x80 | count), literal
// counts followed by the held literal bytes, and a 0x00 end marker.
// burst_last flags the final byte caused by one input.
// An input that closes no run leaves the sequencer idle and gives no bytes.
// An input that closes runs moves the sequencer to its header state, which
// loads the first byte into the output register, then one byte per cycle
// while out_ready is high. The sequencer and single output register emit
// every byte, so in_ready stays low from acceptance until the last result
// byte is loaded. The literal store read, issued a byte ahead, never stalls.
// in_ready is high only while the sequencer is idle, which may overlap a
// byte still waiting in the output register.
// Reset (rst_n low, synchronous) closes any open run without output and
// empties the output register. When out_ready is low the byte holds in the
// output register and the sequencer waits.
`default_nettype none

module frame_delta_run_encoder #(
  parameter int MAX_RUN = fdre_pkg::MAX_RUN_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  fdre_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output fdre_pkg::out_t out_data
);

  localparam int LW = $clog2(MAX_RUN + 1);
  localparam int IW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_LIT  = 2'd2;
  localparam logic [1:0] S_MARK = 2'd3;

  logic [1:0]    st_r, st_nxt;
  logic          run_kind_r, run_kind_nxt;
  logic [LW-1:0] run_len_r, run_len_nxt;
  logic          cur_kind_r, cur_kind_nxt;
  logic [LW-1:0] cur_len_r, cur_len_nxt;
  logic [LW-1:0] b_len_r, b_len_nxt;
  logic          b_pend_r, b_pend_nxt;
  logic          end_pend_r, end_pend_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  fdre_pkg::out_t out_data_r, out_data_nxt;

  // Literal store and its registered read port
  logic [7:0]    lit_mem [MAX_RUN];
  logic [7:0]    rd_data_r;

  logic          in_fire;
  logic          fire;
  logic          kind;
  logic          close_old;
  logic [LW-1:0] new_len;
  logic          close_new;
  logic [IW-1:0] wr_addr;
  logic          last_lit;
  logic          tail_free;

  assign in_ready  = (st_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fire      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Run bookkeeping for the incoming pair
  assign kind      = (in_data.prev_byte == in_data.new_byte) ?
                     fdre_pkg::KIND_MATCH : fdre_pkg::KIND_LITERAL;
  assign close_old = (run_len_r != '0) && (run_kind_r != kind);
  assign new_len   = close_old ? LW'(1) : run_len_r + LW'(1);
  assign close_new = (new_len >= LW'(MAX_RUN)) || in_data.frame_end;
  assign wr_addr   = close_old ? '0 : run_len_r[IW-1:0];
  assign last_lit  = (LW'(idx_r) == cur_len_r - LW'(1));
  assign tail_free = !b_pend_r && !end_pend_r;

  // Sequencer
  always_comb begin
    st_nxt        = st_r;
    run_kind_nxt  = run_kind_r;
    run_len_nxt   = run_len_r;
    cur_kind_nxt  = cur_kind_r;
    cur_len_nxt   = cur_len_r;
    b_len_nxt     = b_len_r;
    b_pend_nxt    = b_pend_r;
    end_pend_nxt  = end_pend_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          run_kind_nxt = kind;
          run_len_nxt  = close_new ? '0 : new_len;
          b_len_nxt    = new_len;
          end_pend_nxt = in_data.frame_end;
          idx_nxt      = '0;
          if (close_old) begin
            cur_kind_nxt = run_kind_r;
            cur_len_nxt  = run_len_r;
            b_pend_nxt   = close_new;
            st_nxt       = S_HDR;
          end else if (close_new) begin
            cur_kind_nxt = kind;
            cur_len_nxt  = new_len;
            b_pend_nxt   = 1'b0;
            st_nxt       = S_HDR;
          end
        end
      end

      S_HDR: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.frame_done = 1'b0;
          if (cur_kind_r == fdre_pkg::KIND_MATCH) begin
            out_data_nxt.out_byte   = fdre_pkg::MATCH_FLAG | 8'(cur_len_r);
            out_data_nxt.burst_last = tail_free;
            if (b_pend_r) begin
              cur_kind_nxt = run_kind_r;
              cur_len_nxt  = b_len_r;
              b_pend_nxt   = 1'b0;
              st_nxt       = S_HDR;
            end else if (end_pend_r) begin
              st_nxt = S_MARK;
            end else begin
              st_nxt = S_IDLE;
            end
          end else begin
            out_data_nxt.out_byte   = 8'(cur_len_r);
            out_data_nxt.burst_last = 1'b0;
            st_nxt = S_LIT;
          end
        end
      end

      S_LIT: begin
        if (fire) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_byte   = rd_data_r;
          out_data_nxt.frame_done = 1'b0;
          out_data_nxt.burst_last = last_lit && tail_free;
          if (last_lit) begin
            idx_nxt = '0;
            if (b_pend_r) begin
              cur_kind_nxt = run_kind_r;
              cur_len_nxt  = b_len_r;
              b_pend_nxt   = 1'b0;
              st_nxt       = S_HDR;
            end else if (end_pend_r) begin
              st_nxt = S_MARK;
            end else begin
              st_nxt = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      S_MARK: begin
        if (fire) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_byte   = fdre_pkg::END_MARK;
          out_data_nxt.burst_last = 1'b1;
          out_data_nxt.frame_done = 1'b1;
          end_pend_nxt            = 1'b0;
          st_nxt                  = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      run_kind_r  <= fdre_pkg::KIND_MATCH;
      run_len_r   <= '0;
      b_pend_r    <= 1'b0;
      end_pend_r  <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      run_kind_r  <= run_kind_nxt;
      run_len_r   <= run_len_nxt;
      b_pend_r    <= b_pend_nxt;
      end_pend_r  <= end_pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_kind_r <= cur_kind_nxt;
    cur_len_r  <= cur_len_nxt;
    b_len_r    <= b_len_nxt;
    out_data_r <= out_data_nxt;
  end

  // Literal store: written on accepted literal pairs, read one index ahead
  always_ff @(posedge clk) begin
    if (in_fire && (kind == fdre_pkg::KIND_LITERAL)) begin
      lit_mem[wr_addr] <= in_data.new_byte;
    end
    rd_data_r <= lit_mem[idx_nxt];
  end

endmodule

`default_nettype wire

### bench/frame_delta_run_encoder_checker.sv
module frame_delta_run_encoder_checker #(
  parameter int MAX_RUN = fdre_pkg::MAX_RUN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  fdre_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  fdre_pkg::out_t out_data,
  output int             fail_count,
  output int             codes_pending,
  output int             codes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the encoder's run state
  logic       run_kind;
  int         run_len;
  logic [7:0] held_bytes [MAX_RUN];

  // Code bytes predicted but not yet seen, oldest first
  fdre_pkg::out_t code_fifo [$];
  // Code bytes caused by the transaction being predicted
  fdre_pkg::out_t burst [$];
  int   fails = 0;
  int   checked = 0;

  initial begin
    fail_count    = 0;
    codes_pending = 0;
    codes_checked = 0;
  end

  function automatic void add_code(logic [7:0] code, logic done);
    fdre_pkg::out_t r;
    r.out_byte   = code;
    r.burst_last = 1'b0;
    r.frame_done = done;
    burst.push_back(r);
  endfunction

  // Close the open run: match header, or literal count plus held bytes
  function automatic void flush_run();
    if (run_len == 0) return;
    if (run_kind == fdre_pkg::KIND_MATCH) begin
      add_code(fdre_pkg::MATCH_FLAG | 8'(run_len), 1'b0);
    end else begin
      add_code(8'(run_len), 1'b0);
      for (int i = 0; i < run_len && i < MAX_RUN; i++) add_code(held_bytes[i], 1'b0);
    end
    run_len = 0;
  endfunction

  // Codes caused by one byte pair
  function automatic void encode_pair(fdre_pkg::in_t item);
    logic kind;
    kind = (item.prev_byte == item.new_byte) ? fdre_pkg::KIND_MATCH : fdre_pkg::KIND_LITERAL;
    burst.delete();
    if (run_len != 0 && run_kind != kind) flush_run();
    run_kind = kind;
    if (kind == fdre_pkg::KIND_LITERAL && run_len < MAX_RUN)
      held_bytes[run_len] = item.new_byte;
    run_len++;
    if (run_len >= MAX_RUN) flush_run();
    if (item.frame_end) begin
      flush_run();
      add_code(fdre_pkg::END_MARK, 1'b1);
    end
    if (burst.size() > 0) burst[burst.size() - 1].burst_last = 1'b1;
    foreach (burst[i]) code_fifo.push_back(burst[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fails++;
    if (fails <= 30)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Predict on each accepted input, compare each accepted code byte
  always @(posedge clk) begin
    fdre_pkg::out_t want;
    if (!rst_n) begin
      run_kind = fdre_pkg::KIND_MATCH;
      run_len  = 0;
      code_fifo.delete();
    end else begin
      if (in_valid && in_ready) encode_pair(in_data);
      if (out_valid && out_ready) begin
        checked++;
        if (code_fifo.size() == 0) begin
          report_mismatch("unexpected code byte", int'(out_data.out_byte), 0);
        end else begin
          want = code_fifo.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(out_data.out_byte), int'(want.out_byte));
          if (out_data.burst_last !== want.burst_last)
            report_mismatch("burst_last", int'(out_data.burst_last), int'(want.burst_last));
          if (out_data.frame_done !== want.frame_done)
            report_mismatch("frame_done", int'(out_data.frame_done), int'(want.frame_done));
        end
      end
    end
    fail_count    <= fails;
    codes_pending <= code_fifo.size();
    codes_checked <= checked;
  end

endmodule

### bench/frame_delta_run_encoder_tb.sv
module frame_delta_run_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 140;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  fdre_pkg::in_t  in_data = '0;
  logic in_ready;
  logic out_valid;
  fdre_pkg::out_t out_data;

  int fail_count;
  int codes_pending;
  int codes_checked;
  int cycles      = 0;
  int burst_left  = 0;
  int pairs_sent  = 0;
  int frames_sent = 0;
  int rx_mode     = 0;
  int rx_count    = 0;

  frame_delta_run_encoder #(.MAX_RUN(fdre_pkg::MAX_RUN_DEF)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  frame_delta_run_encoder_checker #(.MAX_RUN(fdre_pkg::MAX_RUN_DEF)) code_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .codes_pending(codes_pending),
    .codes_checked(codes_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d code bytes outstanding", cycles, codes_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: picks a new backpressure style whenever its random hold counter runs out
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_count <= $urandom_range(20, 100);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // One input transaction, with bursty gaps in front
  task automatic send_pair(input logic [7:0] prev, input logic [7:0] nxt, input logic last);
    int gap;
    fdre_pkg::in_t item;
    item.prev_byte = prev;
    item.new_byte  = nxt;
    item.frame_end = last;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1, 2: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 16);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
    if (last) frames_sent++;
  endtask

  // A run of one kind with random bytes; frame may end inside it
  task automatic send_run(input logic kind, input int len, input logic end_at_close);
    logic [7:0] prev;
    logic [7:0] nxt;
    logic       last;
    for (int i = 0; i < len; i++) begin
      prev = 8'($urandom);
      nxt  = (kind == fdre_pkg::KIND_MATCH) ? prev : prev ^ 8'($urandom_range(1, 255));
      last = ($urandom_range(0, 23) == 0) || (i == len - 1 && end_at_close);
      send_pair(prev, nxt, last);
    end
  endtask

  initial begin
    logic kind;
    int   len;
    int   target;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes, kind changes, frame ends, inputs with no output
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h55, 8'hAA, 1'b0);
    send_pair(8'hAA, 8'h55, 1'b0);
    send_pair(8'h01, 8'h01, 1'b1);
    send_pair(8'h07, 8'h07, 1'b1);
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair(8'h03, 8'h09, 1'b1);
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'h80, 8'h80, 1'b0);
    send_pair(8'h80, 8'h7F, 1'b1);
    send_pair(8'hFE, 8'h01, 1'b0);
    send_pair(8'h7F, 8'h7F, 1'b0);
    send_pair(8'h01, 8'hFE, 1'b1);

    // Random: mostly whole runs, some full or overflowing, plus noise
    target = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < target) begin
      if ($urandom_range(0, 6) != 0) begin
        kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0: len = fdre_pkg::MAX_RUN_DEF;
          1: len = fdre_pkg::MAX_RUN_DEF + $urandom_range(1, 8);
          2: len = 1;
          default: len = $urandom_range(2, 12);
        endcase
        send_run(kind, len, $urandom_range(0, 4) == 0);
      end else begin
        repeat ($urandom_range(1, 6))
          send_pair(8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray bytes
    do @(posedge clk); while (codes_pending != 0);
    repeat (40) @(posedge clk);

    $display("sent %0d byte pairs in %0d complete frames with random stalls on both sides",
             pairs_sent, frames_sent);
    $display("compared %0d code bytes, %0d mismatches", codes_checked, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
